// ===== hw/rtl/ucc_pkg.sv =====
// Shared types and constants for the UPS cycle controller.
package ucc_pkg;

  // Timing constants, in milliseconds
  localparam logic [31:0] HOLD_TIME_MS  = 32'd3000;
  localparam int unsigned MS_PER_SECOND = 1000;
  localparam logic [31:0] RESET_ON_MS   = 32'd60000;
  localparam logic [31:0] RESET_OFF_MS  = 32'd60000;

  // Reciprocal for the ms-to-seconds conversion: estimate is exact or one low
  localparam int unsigned  SEC_SHIFT   = $clog2(MS_PER_SECOND);
  localparam int unsigned  RECIP_SHIFT = 31 + SEC_SHIFT;
  localparam logic [63:0]  RECIP_WIDE  = (64'd1 << RECIP_SHIFT) / 64'(MS_PER_SECOND);
  localparam logic [31:0]  RECIP_MULT  = RECIP_WIDE[31:0];
  localparam logic [31:0]  MS_DIVISOR  = 32'(MS_PER_SECOND);

  localparam int unsigned SECS_W = 23;

  // Result queue behind the divider pipeline
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // Configuration port
  localparam int unsigned PADDR_W = 3;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_ALLOW = 2'd1,
    REQ_MODE  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_CYCLE = 2'd2
  } mode_e;

  typedef enum logic {
    REG_ON_TIME  = 1'b0,
    REG_OFF_TIME = 1'b1
  } reg_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic       ups_sense;
    logic       button_busy;
    logic       allow_value;
    logic [1:0] mode_value;
  } in_t;

  typedef struct packed {
    logic              press_button;
    logic              ups_on;
    logic [1:0]        active_mode;
    logic              allowed_now;
    logic              holding;
    logic [SECS_W-1:0] seconds_to_switch;
  } out_t;

  // Status bits that travel beside the remaining time through the divider
  typedef struct packed {
    logic       press_button;
    logic       ups_on;
    logic [1:0] active_mode;
    logic       allowed_now;
    logic       holding;
  } stat_t;

endpackage

// ===== hw/rtl/ucc_cfg_regs.sv =====
// APB-style configuration registers: cycle on and off times.
module ucc_cfg_regs
  import ucc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [31:0]        on_time_o,
  output logic [31:0]        off_time_o
);

  logic [31:0] on_time_q, on_time_d;
  logic [31:0] off_time_q, off_time_d;
  logic        wr_en;
  reg_e        sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = reg_e'(paddr[2]);

  always_comb begin
    on_time_d  = on_time_q;
    off_time_d = off_time_q;
    if (wr_en) begin
      case (sel)
        REG_ON_TIME:  on_time_d  = pwdata;
        REG_OFF_TIME: off_time_d = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_time_q  <= RESET_ON_MS;
      off_time_q <= RESET_OFF_MS;
    end else begin
      on_time_q  <= on_time_d;
      off_time_q <= off_time_d;
    end
  end

  always_comb begin
    case (sel)
      REG_ON_TIME:  prdata = on_time_q;
      REG_OFF_TIME: prdata = off_time_q;
      default:      prdata = '0;
    endcase
  end

  assign on_time_o  = on_time_q;
  assign off_time_o = off_time_q;

endmodule

// ===== hw/rtl/ucc_core.sv =====
// Controller state and per-item update; registers status and time to switch.
module ucc_core
  import ucc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] on_time_i,
  input  logic [31:0] off_time_i,
  input  logic        item_valid_i,
  input  in_t         item_i,
  output logic        res_valid_o,
  output stat_t       res_stat_o,
  output logic [31:0] res_rem_o
);

  logic [31:0] clock_q, clock_d;
  logic [31:0] next_sw_q, next_sw_d;
  logic [31:0] saved_rem_q, saved_rem_d;
  logic        on_q, on_d;
  logic [1:0]  mode_q, mode_d;
  logic [1:0]  pers_q, pers_d;
  logic        allow_q, allow_d;
  logic        hold_q, hold_d;
  logic        saved_on_q, saved_on_d;
  logic        restore_q, restore_d;
  logic        press;
  logic [31:0] now;
  logic [31:0] rem;
  logic        busy;

  logic        res_valid_q;
  stat_t       res_stat_q;
  logic [31:0] res_rem_q;

  assign busy = item_i.button_busy;
  assign now  = clock_q + 32'd1;

  always_comb begin
    clock_d     = clock_q;
    next_sw_d   = next_sw_q;
    saved_rem_d = saved_rem_q;
    on_d        = on_q;
    mode_d      = mode_q;
    pers_d      = pers_q;
    allow_d     = allow_q;
    hold_d      = hold_q;
    saved_on_d  = saved_on_q;
    restore_d   = restore_q;
    press       = 1'b0;

    if (item_valid_i) begin
      case (item_i.req_type)
        REQ_TICK: begin
          clock_d = now;
          if (hold_q) begin
            if (now >= HOLD_TIME_MS) begin
              hold_d  = 1'b0;
              allow_d = 1'b1;
              if (mode_q == MODE_CYCLE && !restore_q)
                next_sw_d = now + (on_q ? on_time_i : off_time_i);
            end
          end else begin
            // follow the sensed state unless a restore is pending
            if (item_i.ups_sense != on_q && !restore_q) begin
              on_d = item_i.ups_sense;
              if (mode_q == MODE_CYCLE)
                next_sw_d = now + (on_d ? on_time_i : off_time_i);
            end
            if (!allow_q) begin
              next_sw_d = '0;
              press     = on_d && !busy;
            end else begin
              case (mode_q)
                MODE_ON: begin
                  next_sw_d = '0;
                  press     = !on_d && !busy;
                end
                MODE_OFF: begin
                  next_sw_d = '0;
                  press     = on_d && !busy;
                end
                MODE_CYCLE: begin
                  if (restore_q && saved_on_q && !on_d && !busy) begin
                    press = 1'b1;
                    on_d  = 1'b1;
                  end
                  if (next_sw_d != '0 && now >= next_sw_d && !busy) begin
                    press     = 1'b1;
                    next_sw_d = now + (on_d ? on_time_i : off_time_i);
                    restore_d = 1'b0;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        REQ_ALLOW: begin
          allow_d = item_i.allow_value;
          if (!item_i.allow_value) begin
            saved_on_d  = on_q;
            saved_rem_d = next_sw_q - clock_q;
            press       = !hold_q && on_q && !busy;
            mode_d      = MODE_OFF;
            next_sw_d   = '0;
          end else begin
            mode_d = pers_q;
            if (!hold_q && pers_q == MODE_CYCLE) begin
              next_sw_d = clock_q + saved_rem_q;
              restore_d = 1'b1;
            end
          end
        end
        REQ_MODE: begin
          if (item_i.mode_value inside {MODE_OFF, MODE_ON, MODE_CYCLE}) begin
            mode_d = item_i.mode_value;
            pers_d = item_i.mode_value;
            if (!hold_q && item_i.mode_value == MODE_CYCLE)
              next_sw_d = clock_q + (on_q ? on_time_i : off_time_i);
          end
        end
        default: ;
      endcase
    end
  end

  // Milliseconds to the next switch, zero when none is pending or the switch is already due
  assign rem = (next_sw_d != '0 && next_sw_d > clock_d) ? (next_sw_d - clock_d) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q     <= '0;
      next_sw_q   <= '0;
      saved_rem_q <= '0;
      on_q        <= 1'b0;
      mode_q      <= MODE_CYCLE;
      pers_q      <= MODE_CYCLE;
      allow_q     <= 1'b0;
      hold_q      <= 1'b1;
      saved_on_q  <= 1'b0;
      restore_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      clock_q     <= clock_d;
      next_sw_q   <= next_sw_d;
      saved_rem_q <= saved_rem_d;
      on_q        <= on_d;
      mode_q      <= mode_d;
      pers_q      <= pers_d;
      allow_q     <= allow_d;
      hold_q      <= hold_d;
      saved_on_q  <= saved_on_d;
      restore_q   <= restore_d;
      res_valid_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_valid_i) begin
      res_stat_q.press_button <= press;
      res_stat_q.ups_on       <= on_d;
      res_stat_q.active_mode  <= mode_d;
      res_stat_q.allowed_now  <= allow_d;
      res_stat_q.holding      <= hold_d;
      res_rem_q               <= rem;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_stat_o  = res_stat_q;
  assign res_rem_o   = res_rem_q;

endmodule

// ===== hw/rtl/ucc_sec_div.sv =====
// Pipelined ms-to-seconds conversion by reciprocal multiply and one correction.
module ucc_sec_div
  import ucc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  stat_t       stat_i,
  input  logic [31:0] rem_i,
  output logic        valid_o,
  output out_t        res_o
);

  // stage a: reciprocal product
  logic        va_q;
  stat_t       sa_q;
  logic [31:0] ra_q;
  logic [63:0] prod_q;
  // stage b: quotient estimate
  logic        vb_q;
  stat_t       sb_q;
  logic [31:0] rb_q;
  logic [31:0] qe_q;
  logic [63:0] qe_wide;
  // stage c: estimate times divisor
  logic        vc_q;
  stat_t       sc_q;
  logic [31:0] rc_q;
  logic [31:0] qc_q;
  logic [31:0] qd_q;
  logic [31:0] resid;
  logic [31:0] quot;

  assign qe_wide = prod_q >> RECIP_SHIFT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_q   <= stat_i;
    ra_q   <= rem_i;
    prod_q <= 64'(rem_i) * 64'(RECIP_MULT);
    sb_q   <= sa_q;
    rb_q   <= ra_q;
    qe_q   <= qe_wide[31:0];
    sc_q   <= sb_q;
    rc_q   <= rb_q;
    qc_q   <= qe_q;
    qd_q   <= 32'(qe_q * MS_DIVISOR);
  end

  // estimate is at most one low; fix it with one compare
  assign resid = rc_q - qd_q;
  assign quot  = (resid >= MS_DIVISOR) ? (qc_q + 32'd1) : qc_q;

  assign valid_o                = vc_q;
  assign res_o.press_button      = sc_q.press_button;
  assign res_o.ups_on            = sc_q.ups_on;
  assign res_o.active_mode       = sc_q.active_mode;
  assign res_o.allowed_now       = sc_q.allowed_now;
  assign res_o.holding           = sc_q.holding;
  assign res_o.seconds_to_switch = quot[SECS_W-1:0];

endmodule

// ===== hw/rtl/ucc_out_fifo.sv =====
// Small result queue in front of the output channel.
module ucc_out_fifo
  import ucc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  out_t data_i,
  output logic valid_o,
  input  logic stall_i,
  output out_t data_o
);

  out_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;
  logic               pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && !stall_i;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop)    rd_q <= rd_q + 1'b1;
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

// ===== hw/rtl/ups_cycle_controller.sv =====
// Top level of the UPS cycle controller: config regs, core, divider, result queue.
// Path from input transfer to result valid: the input reg loads at the transfer
//   edge, then state update, three divider stages, result queue.
// Throughput: one item per cycle; the result queue holds 8 results, so input
//   stalls only once 8 results are in flight or waiting downstream.
// Reset: asynchronous, active low; state returns to cycle mode with the startup
//   hold running, on and off times return to 60000 ms. No clearing pass.
module ups_cycle_controller
  import ucc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [31:0]      on_time, off_time;
  logic             in_xfer, out_xfer;
  logic [FIFO_AW:0] credit_q;

  // input register
  logic             v0_q;
  in_t              in_q;

  logic             core_valid;
  stat_t            core_stat;
  logic [31:0]      core_rem;

  logic             div_valid;
  out_t             div_res;

  ucc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .on_time_o  (on_time),
    .off_time_o (off_time)
  );

  // Credit count: items accepted and not yet transferred out. Capping it at
  // the queue depth means the pipeline never has to stop; the stall flag is
  // taken from a register only, so it never depends on out_stall_i.
  assign in_stall_o = (credit_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
      v0_q     <= 1'b0;
    end else begin
      case ({in_xfer, out_xfer})
        2'b10:   credit_q <= credit_q + 1'b1;
        2'b01:   credit_q <= credit_q - 1'b1;
        default: ;
      endcase
      v0_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) in_q <= in_data_i;
  end

  // State update: one item per cycle, result registered with its remaining time
  ucc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .on_time_i    (on_time),
    .off_time_i   (off_time),
    .item_valid_i (v0_q),
    .item_i       (in_q),
    .res_valid_o  (core_valid),
    .res_stat_o   (core_stat),
    .res_rem_o    (core_rem)
  );

  // Remaining ms to whole seconds; status rides along
  ucc_sec_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (core_valid),
    .stat_i  (core_stat),
    .rem_i   (core_rem),
    .valid_o (div_valid),
    .res_o   (div_res)
  );

  // Results wait here while the output side stalls
  ucc_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (div_valid),
    .data_i  (div_res),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

endmodule

// ===== dv/ucc_checker.sv =====
`timescale 1ns / 100ps
// Checker for the UPS cycle controller: mirrors the controller state and compares every result.
module ucc_checker
  import ucc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  in_t                in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  out_t               out_data_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic               pready_i,
  output int unsigned        errors_o,
  output int unsigned        pending_o
);

  // Mirrored configuration and controller state
  logic [31:0] on_ms, off_ms;
  logic [31:0] clock_now, next_switch, saved_left;
  logic        tracked_on, saved_on, allow_on, hold_on, restoring;
  mode_e       cur_mode, keep_mode;

  out_t        expected_status_q[$];
  out_t        predicted, observed;
  int unsigned mismatches;

  function automatic logic [31:0] switch_due();
    return clock_now + (tracked_on ? on_ms : off_ms);
  endfunction

  task automatic reset_mirror();
    on_ms       = RESET_ON_MS;
    off_ms      = RESET_OFF_MS;
    clock_now   = '0;
    next_switch = '0;
    saved_left  = '0;
    tracked_on  = 1'b0;
    saved_on    = 1'b0;
    allow_on    = 1'b0;
    hold_on     = 1'b1;
    restoring   = 1'b0;
    cur_mode    = MODE_CYCLE;
    keep_mode   = MODE_CYCLE;
  endtask

  task automatic predict_status(input in_t item, output out_t status);
    logic press;
    press = 1'b0;
    case (item.req_type)
      REQ_TICK: begin
        clock_now = clock_now + 1;
        if (hold_on) begin
          if (clock_now >= HOLD_TIME_MS) begin
            hold_on  = 1'b0;
            allow_on = 1'b1;
            if (cur_mode == MODE_CYCLE && !restoring) next_switch = switch_due();
          end
        end else begin
          if (item.ups_sense != tracked_on && !restoring) begin
            tracked_on = item.ups_sense;
            if (cur_mode == MODE_CYCLE) next_switch = switch_due();
          end
          if (!allow_on) begin
            next_switch = '0;
            press       = tracked_on && !item.button_busy;
          end else begin
            case (cur_mode)
              MODE_ON: begin
                next_switch = '0;
                press       = !tracked_on && !item.button_busy;
              end
              MODE_OFF: begin
                next_switch = '0;
                press       = tracked_on && !item.button_busy;
              end
              MODE_CYCLE: begin
                // restore the saved on state before the pending switch
                if (restoring && saved_on && !tracked_on && !item.button_busy) begin
                  press      = 1'b1;
                  tracked_on = 1'b1;
                end
                if (next_switch != 0 && clock_now >= next_switch && !item.button_busy) begin
                  press       = 1'b1;
                  next_switch = switch_due();
                  restoring   = 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
      end
      REQ_ALLOW: begin
        allow_on = item.allow_value;
        if (!item.allow_value) begin
          saved_on    = tracked_on;
          saved_left  = next_switch - clock_now;
          press       = !hold_on && tracked_on && !item.button_busy;
          cur_mode    = MODE_OFF;
          next_switch = '0;
        end else begin
          cur_mode = keep_mode;
          if (!hold_on && cur_mode == MODE_CYCLE) begin
            next_switch = clock_now + saved_left;
            restoring   = 1'b1;
          end
        end
      end
      REQ_MODE: begin
        if (item.mode_value <= MODE_CYCLE) begin
          cur_mode  = mode_e'(item.mode_value);
          keep_mode = mode_e'(item.mode_value);
          if (!hold_on && cur_mode == MODE_CYCLE) next_switch = switch_due();
        end
      end
      default: ;
    endcase

    status.press_button      = press;
    status.ups_on            = tracked_on;
    status.active_mode       = cur_mode;
    status.allowed_now       = allow_on;
    status.holding           = hold_on;
    status.seconds_to_switch = '0;
    if (next_switch != 0 && next_switch > clock_now)
      status.seconds_to_switch = SECS_W'((next_switch - clock_now) / MS_PER_SECOND);
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_mirror();
      expected_status_q.delete();
      mismatches = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (reg_e'(paddr_i[2]) == REG_ON_TIME) on_ms = pwdata_i;
        else off_ms = pwdata_i;
      end
      if (out_valid_i && !out_stall_i) begin
        observed = out_data_i;
        if (expected_status_q.size() == 0) begin
          $error("result with nothing expected: %h", observed);
          mismatches++;
        end else begin
          predicted = expected_status_q.pop_front();
          check_field("press_button", 32'(predicted.press_button),
                      32'(observed.press_button));
          check_field("ups_on", 32'(predicted.ups_on), 32'(observed.ups_on));
          check_field("active_mode", 32'(predicted.active_mode),
                      32'(observed.active_mode));
          check_field("allowed_now", 32'(predicted.allowed_now),
                      32'(observed.allowed_now));
          check_field("holding", 32'(predicted.holding), 32'(observed.holding));
          check_field("seconds_to_switch", 32'(predicted.seconds_to_switch),
                      32'(observed.seconds_to_switch));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_status(in_data_i, predicted);
        expected_status_q.push_back(predicted);
      end
    end
    errors_o  <= mismatches;
    pending_o <= expected_status_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the UPS cycle controller testbench: stimulus, register setup and verdict.
module testbench
  import ucc_pkg::*;
();

  // Request type and mode value that the block must ignore
  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int unsigned RUN_LIMIT = 600000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_e;

  logic               clk_i;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_t                in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_t               out_data;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [31:0]        pwdata    = '0;
  logic [31:0]        prdata;
  logic               pready;

  int unsigned  mismatches, pending;
  int unsigned  cycle_count = 0;
  int unsigned  ticks_sent  = 0;   // equals the block's millisecond clock
  int unsigned  burst_left  = 0;
  bit           no_idle     = 1'b0;
  logic         ups_power   = 1'b0; // slowly wandering sensed power state
  stall_style_e stall_style = STALL_NONE;
  int unsigned  stall_left  = 0;

  ups_cycle_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  ucc_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pready_i    (pready),
    .errors_o    (mismatches),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Output stall: each style holds for a random stretch, including stretches of no stall
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_style <= stall_style_e'($urandom_range(3));
      stall_left  <= $urandom_range(300, 40);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(3) != 0);
      default:     out_stall <= ((cycle_count % 7) < 3);
    endcase
  end

  function automatic in_t item_of(input logic [1:0] kind, input logic sense,
                                  input logic busy, input logic allow,
                                  input logic [1:0] mode);
    in_t item;
    item.req_type    = kind;
    item.ups_sense   = sense;
    item.button_busy = busy;
    item.allow_value = allow;
    item.mode_value  = mode;
    return item;
  endfunction

  // Mostly ticks with a sensed state that follows the UPS slowly; allow requests
  // are allows more often than blocks; mode sets and unused codes sprinkled in.
  function automatic in_t random_item();
    in_t         item;
    int unsigned pick;
    pick = $urandom_range(99);
    if ($urandom_range(11) == 0) ups_power = ~ups_power;
    item = item_of(REQ_TICK, ups_power, $urandom_range(3) == 0, 1'($urandom_range(1)),
                   2'($urandom_range(3)));
    if (pick >= 97) begin
      item.req_type = REQ_UNUSED;
    end else if (pick >= 88) begin
      item.req_type   = REQ_MODE;
      item.mode_value = ($urandom_range(9) == 0) ? MODE_UNUSED : 2'($urandom_range(2));
    end else if (pick >= 78) begin
      item.req_type    = REQ_ALLOW;
      item.allow_value = ($urandom_range(4) < 3);
    end
    return item;
  endfunction

  // One transfer: valid stays up across a burst, then a random gap
  task automatic send_item(input in_t item);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (item.req_type == REQ_TICK) ticks_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(24);
      gap = no_idle ? 0 : $urandom_range(6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_item(random_item());
  endtask

  // Hold off until every result is back, then let the pipeline drain fully.
  // The first edge lets the checker's count catch up with the last transfer.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Registers only change with the block idle
  task automatic retune(input logic [31:0] on_ms, input logic [31:0] off_ms);
    settle();
    apb_write(REG_ON_TIME, on_ms);
    apb_write(REG_OFF_TIME, off_ms);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;

    retune(32'd12, 32'd9);

    // During the startup hold: ignored codes, every mode, a block that the
    // hold end must override, and all sense/busy combinations on ticks.
    send_item(item_of(REQ_UNUSED, 1'b1, 1'b0, 1'b1, MODE_UNUSED));
    send_item(item_of(REQ_MODE, 1'b1, 1'b0, 1'b0, MODE_UNUSED));
    send_item(item_of(REQ_MODE, 1'b0, 1'b0, 1'b0, MODE_OFF));
    send_item(item_of(REQ_MODE, 1'b0, 1'b0, 1'b0, MODE_ON));
    send_item(item_of(REQ_MODE, 1'b0, 1'b0, 1'b0, MODE_CYCLE));
    send_item(item_of(REQ_ALLOW, 1'b1, 1'b0, 1'b0, MODE_OFF));
    send_item(item_of(REQ_ALLOW, 1'b0, 1'b1, 1'b1, MODE_OFF));
    send_item(item_of(REQ_ALLOW, 1'b1, 1'b0, 1'b0, MODE_OFF));
    send_item(item_of(REQ_TICK, 1'b0, 1'b0, 1'b0, MODE_OFF));
    send_item(item_of(REQ_TICK, 1'b0, 1'b1, 1'b0, MODE_OFF));
    send_item(item_of(REQ_TICK, 1'b1, 1'b0, 1'b0, MODE_OFF));
    send_item(item_of(REQ_TICK, 1'b1, 1'b1, 1'b0, MODE_OFF));

    // Run the clock up to the end of the hold
    while (ticks_sent < HOLD_TIME_MS)
      send_item(item_of(REQ_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)), 2'($urandom_range(3))));

    // After the hold: manual off with the UPS on, manual on with it off,
    // cycle, a block while on, a block with nothing scheduled, then restore.
    send_item(item_of(REQ_TICK, 1'b1, 1'b1, 1'b0, MODE_OFF));
    send_item(item_of(REQ_TICK, 1'b1, 1'b0, 1'b0, MODE_OFF));
    send_item(item_of(REQ_TICK, 1'b0, 1'b0, 1'b0, MODE_OFF));
    send_item(item_of(REQ_MODE, 1'b0, 1'b0, 1'b0, MODE_ON));
    send_item(item_of(REQ_TICK, 1'b0, 1'b1, 1'b0, MODE_OFF));
    send_item(item_of(REQ_TICK, 1'b0, 1'b0, 1'b0, MODE_OFF));
    send_item(item_of(REQ_MODE, 1'b1, 1'b0, 1'b0, MODE_CYCLE));
    send_item(item_of(REQ_TICK, 1'b1, 1'b0, 1'b0, MODE_OFF));
    send_item(item_of(REQ_TICK, 1'b1, 1'b0, 1'b0, MODE_OFF));
    send_item(item_of(REQ_ALLOW, 1'b1, 1'b0, 1'b0, MODE_OFF));
    send_item(item_of(REQ_ALLOW, 1'b1, 1'b0, 1'b0, MODE_OFF));
    send_item(item_of(REQ_ALLOW, 1'b0, 1'b0, 1'b1, MODE_OFF));
    send_item(item_of(REQ_TICK, 1'b0, 1'b0, 1'b0, MODE_OFF));
    send_item(item_of(REQ_TICK, 1'b0, 1'b1, 1'b0, MODE_OFF));
    send_item(item_of(REQ_TICK, 1'b1, 1'b0, 1'b0, MODE_OFF));

    // Short cycle times so switches happen often
    retune($urandom_range(40, 1), $urandom_range(40, 1));
    run_random(300);

    // Zero times: every switch is due at once
    retune(32'd0, 32'd0);
    run_random(200);

    // Largest on time wraps to just behind the clock
    retune(32'hFFFF_FFFF, 32'd3);
    run_random(200);

    // On time far ahead: large seconds-to-switch values
    retune(32'hFFFF_FFF0 - ticks_sent - 32'd1000, 32'd1);
    send_item(item_of(REQ_MODE, 1'b1, 1'b0, 1'b0, MODE_CYCLE));
    send_item(item_of(REQ_TICK, 1'b1, 1'b0, 1'b0, MODE_OFF));
    run_random(200);

    // Times that land the schedule exactly on zero, then a block with
    // nothing scheduled and a restore that wraps back the same way
    retune(32'd0 - ticks_sent, 32'd0 - ticks_sent);
    send_item(item_of(REQ_MODE, 1'b0, 1'b0, 1'b0, MODE_CYCLE));
    send_item(item_of(REQ_ALLOW, 1'b0, 1'b0, 1'b0, MODE_OFF));
    send_item(item_of(REQ_ALLOW, 1'b0, 1'b0, 1'b0, MODE_OFF));
    send_item(item_of(REQ_ALLOW, 1'b0, 1'b0, 1'b1, MODE_OFF));
    send_item(item_of(REQ_TICK, 1'b0, 1'b0, 1'b0, MODE_OFF));
    run_random(100);

    // Back-to-back stretch without sender gaps
    retune($urandom_range(60, 1), $urandom_range(60, 1));
    no_idle = 1'b1;
    run_random(250);

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
